### src/adfp_pkg.sv
// Shared types, constants and the power-of-ten table of the ASCII decimal converter.
`timescale 1ns / 1ps
package adfp_pkg;

	// Default and largest number of fraction digits.
	localparam int FRAC_DIGITS_DEF = 8;
	localparam int FRAC_DIGITS_MAX = 18;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Width of an exponent that selects an entry of the power table.
	localparam int EXP_W = $clog2(FRAC_DIGITS_MAX + 1);

	// Width of one table entry: ten to the eighteenth fits in 60 bits.
	localparam int POW_W = 60;

	// Powers of ten from ten to the zero up to ten to the eighteenth.
	localparam logic [POW_W-1:0] POW10 [0:FRAC_DIGITS_MAX] = '{
		60'd1,
		60'd10,
		60'd100,
		60'd1000,
		60'd10000,
		60'd100000,
		60'd1000000,
		60'd10000000,
		60'd100000000,
		60'd1000000000,
		60'd10000000000,
		60'd100000000000,
		60'd1000000000000,
		60'd10000000000000,
		60'd100000000000000,
		60'd1000000000000000,
		60'd10000000000000000,
		60'd100000000000000000,
		60'd1000000000000000000
	};

	// One step for the accumulator: optionally scale it by ten, then add the term.
	// The term is already scaled to the fixed-point weight of its digit and signed.
	typedef struct packed {
		logic        last;
		logic        mul_ten;
		logic [63:0] term;
	} adfp_op_t;

endpackage

### src/ascii_decimal_to_fixed_point.sv
// Top level of the ASCII decimal string to signed fixed-point converter.
`timescale 1ns / 1ps
//
// Usage:
//   The request channel (req_valid, req_stall) carries one character a
//   transaction: char_code, char_valid and is_last. An item with is_last set,
//   or with char_valid clear, ends the string. The response channel
//   (rsp_valid, rsp_stall) carries one fixed_value per string: the number
//   times ten to the FRAC_DIGITS, two's complement, wrapping modulo 2^64.
//   The last transaction of a string passes through the queue; its final
//   step loads the result register and sets rsp_valid. Throughput: one
//   character per cycle while the queue is not full. The front end forms
//   each digit's weighted term with one constant-table multiply, and the
//   back end folds it into the accumulator with one shift-add per cycle.
//   When the receiver stalls a result, the result register holds, a final
//   step waits and the QUEUE_DEPTH-step queue fills; req_stall rises when full.
//   Reset clears the parse state, the accumulator, the queue and rsp_valid.
//
module ascii_decimal_to_fixed_point #(
	parameter int FRAC_DIGITS = adfp_pkg::FRAC_DIGITS_DEF,
	parameter int QUEUE_DEPTH = adfp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  char_code,
	input  logic        char_valid,
	input  logic        is_last,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] fixed_value
);
	import adfp_pkg::*;

	adfp_op_t push_op;
	adfp_op_t head_op;
	logic     push;
	logic     pop;
	logic     empty;
	logic     full;

	assign req_stall = full;

	// Character classification and term building.
	adfp_front #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.char_code (char_code),
		.char_valid(char_valid),
		.is_last   (is_last),
		.push      (push),
		.push_op   (push_op)
	);

	// Decoupling queue.
	adfp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.head_op(head_op),
		.empty  (empty),
		.full   (full)
	);

	// Accumulation and result register.
	adfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_op    (head_op),
		.empty      (empty),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.fixed_value(fixed_value)
	);

endmodule

### src/adfp_front.sv
// Front end: accepts characters, tracks the parse phase and builds weighted digit terms.
`timescale 1ns / 1ps
module adfp_front #(
	parameter int FRAC_DIGITS = adfp_pkg::FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [7:0]         char_code,
	input  logic               char_valid,
	input  logic               is_last,
	output logic               push,
	output adfp_pkg::adfp_op_t push_op
);
	import adfp_pkg::*;

	localparam int CNT_W = $clog2(FRAC_DIGITS + 1);

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_POINT = 8'd46;

	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_INT   = 3'b010,
		PH_FRAC  = 3'b100
	} phase_t;

	phase_t             phase_q, phase_n;
	logic               neg_q, neg_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               is_digit;
	logic               is_int;
	logic               end_str;
	logic               accept;
	logic [EXP_W-1:0]   exp_sel;
	logic signed [9:0]  digit;
	logic signed [9:0]  digit_sgn;
	logic signed [70:0] prod;

	assign accept = req_valid && !req_stall;

	// Classify the character against the current phase.
	always_comb begin
		phase_n  = phase_q;
		neg_n    = neg_q;
		cnt_n    = cnt_q;
		is_digit = 1'b0;
		is_int   = 1'b0;
		if (char_valid) begin
			unique case (phase_q)
				PH_START: begin
					phase_n = PH_INT;
					if (char_code == CH_MINUS) begin
						neg_n = 1'b1;
					end else if (char_code == CH_POINT) begin
						phase_n = PH_FRAC;
					end else begin
						is_digit = 1'b1;
						is_int   = 1'b1;
					end
				end
				PH_INT: begin
					if (char_code == CH_POINT) begin
						phase_n = PH_FRAC;
					end else begin
						is_digit = 1'b1;
						is_int   = 1'b1;
					end
				end
				PH_FRAC: begin
					if (cnt_q < CNT_W'(FRAC_DIGITS)) begin
						is_digit = 1'b1;
						cnt_n    = cnt_q + CNT_W'(1);
					end
				end
				default: begin
					phase_n = PH_START;
				end
			endcase
		end
		end_str = !char_valid || is_last;
	end

	// Weight of the digit: ten to the FRAC_DIGITS for the integer part,
	// falling by one decade for each fraction digit.
	assign exp_sel = is_int ? EXP_W'(FRAC_DIGITS)
		: EXP_W'(FRAC_DIGITS - 1) - EXP_W'(cnt_q);

	// Digit value wraps below the code for zero; a negative number builds up negated.
	assign digit     = $signed({2'b00, char_code}) - $signed({2'b00, CH_ZERO});
	assign digit_sgn = neg_q ? -digit : digit;
	assign prod      = digit_sgn * $signed({1'b0, POW10[exp_sel]});

	assign push            = accept && (is_digit || end_str);
	assign push_op.last    = end_str;
	assign push_op.mul_ten = is_int;
	assign push_op.term    = is_digit ? prod[63:0] : 64'd0;

	// Parse state returns to the start of a string after its last transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (end_str) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				cnt_q   <= cnt_n;
			end
		end
	end

`ifndef SYNTHESIS
	// A finished string leaves the parser fresh.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_op.last |=> phase_q == PH_START && cnt_q == '0 && !neg_q)
		else $error("parser state not cleared after end of string");

	// Fraction digits are only counted in the fraction phase.
	a_cnt_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_FRAC |-> cnt_q == '0)
		else $error("fraction count set outside fraction phase");
`endif

endmodule

### src/adfp_queue.sv
// Short queue of accumulator steps between the front end and the back end.
`timescale 1ns / 1ps
module adfp_queue #(
	parameter int DEPTH = adfp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  adfp_pkg::adfp_op_t push_op,
	input  logic               pop,
	output adfp_pkg::adfp_op_t head_op,
	output logic               empty,
	output logic               full
);
	import adfp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	adfp_op_t         slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign head_op = slot_q[rd_ptr_q];

	// Storage slots carry payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// The back end never takes a step from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule

### src/adfp_back.sv
// Back end: applies queued steps to the accumulator and holds the finished result.
`timescale 1ns / 1ps
module adfp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  adfp_pkg::adfp_op_t head_op,
	input  logic               empty,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [63:0]        fixed_value
);
	import adfp_pkg::*;

	logic [63:0] acc_q;
	logic [63:0] scaled;
	logic [63:0] sum;
	logic        out_valid_q;
	logic [63:0] out_value_q;

	// A final step waits only while the output register is full and stalled.
	assign pop = !empty && (!head_op.last || !out_valid_q || !rsp_stall);

	// Times ten as eight plus two, then add the weighted digit.
	assign scaled = head_op.mul_ten ? ((acc_q << 3) + (acc_q << 1)) : acc_q;
	assign sum    = scaled + head_op.term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= head_op.last ? 64'd0 : sum;
			end
			if (pop && head_op.last) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register needs no reset.
	always_ff @(posedge clk) begin
		if (pop && head_op.last) begin
			out_value_q <= sum;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign fixed_value = out_value_q;

`ifndef SYNTHESIS
	// Every final step shows up as a result in the next cycle.
	a_last_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_op.last |=> rsp_valid && acc_q == 64'd0)
		else $error("final step did not produce a result");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for the ASCII decimal string to fixed-point converter.
`timescale 1ns / 1ps

// Phases of the string parser as the checker tracks them.
typedef enum logic [1:0] {
	PHASE_START = 2'd0,
	PHASE_INT   = 2'd1,
	PHASE_FRAC  = 2'd2
} parse_phase_t;

// Character codes with a meaning of their own.
localparam logic [7:0] CODE_ZERO  = 8'd48;
localparam logic [7:0] CODE_MINUS = 8'd45;
localparam logic [7:0] CODE_POINT = 8'd46;

// Tracks the parse of each string and holds the fixed-point values still owed by the block.
class decimal_parse_tracker;
	parse_phase_t phase;
	bit negative;
	logic [63:0] int_acc;
	logic [63:0] frac_acc;
	int unsigned frac_cnt;
	logic [63:0] owed_values[$];
	int unsigned mismatches;
	int unsigned values_seen;

	function new();
		clear();
		mismatches = 0;
		values_seen = 0;
	endfunction

	function void clear();
		phase = PHASE_START;
		negative = 1'b0;
		int_acc = 64'd0;
		frac_acc = 64'd0;
		frac_cnt = 0;
	endfunction

	function logic [63:0] ten_to(input int unsigned n);
		logic [63:0] v;
		v = 64'd1;
		for (int unsigned i = 0; i < n; i++)
			v = v * 64'd10;
		return v;
	endfunction

	// Every character adds its code minus the code of zero, wrapping.
	function logic [63:0] digit_of(input logic [7:0] code);
		return {56'd0, code} - {56'd0, CODE_ZERO};
	endfunction

	// Scales the parsed parts to the fixed-point weight and applies the sign.
	function logic [63:0] scaled_value();
		logic [63:0] frac;
		logic [63:0] total;
		frac = frac_acc;
		if (frac_cnt < adfp_pkg::FRAC_DIGITS_DEF)
			frac = frac * ten_to(adfp_pkg::FRAC_DIGITS_DEF - frac_cnt);
		total = int_acc * ten_to(adfp_pkg::FRAC_DIGITS_DEF) + frac;
		if (negative)
			total = 64'd0 - total;
		return total;
	endfunction

	// Notes one accepted input transaction and queues the value it completes, if any.
	function void take_char(input logic [7:0] code, input logic cv, input logic last);
		if (cv) begin
			case (phase)
				PHASE_START: begin
					if (code == CODE_MINUS) begin
						negative = 1'b1;
						phase = PHASE_INT;
					end else if (code == CODE_POINT) begin
						phase = PHASE_FRAC;
					end else begin
						int_acc = int_acc * 64'd10 + digit_of(code);
						phase = PHASE_INT;
					end
				end
				PHASE_INT: begin
					if (code == CODE_POINT)
						phase = PHASE_FRAC;
					else
						int_acc = int_acc * 64'd10 + digit_of(code);
				end
				default: begin
					// Digits past the fraction width are dropped.
					if (frac_cnt < adfp_pkg::FRAC_DIGITS_DEF) begin
						frac_acc = frac_acc * 64'd10 + digit_of(code);
						frac_cnt++;
					end
				end
			endcase
			if (!last)
				return;
		end
		owed_values.push_back(scaled_value());
		clear();
	endfunction

	// Compares one accepted result transaction with the oldest owed value.
	function void check_value(input logic [63:0] got);
		logic [63:0] want;
		values_seen++;
		if (owed_values.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %0d",
				$time, $signed(got));
			mismatches++;
			return;
		end
		want = owed_values.pop_front();
		if (got !== want) begin
			$display("%0t: fixed_value mismatch, expected %0d, actual %0d",
				$time, $signed(want), $signed(got));
			mismatches++;
		end
	endfunction
endclass

module tb;
	localparam int HALF_PERIOD = 2;
	localparam int ITEM_TARGET = 1600;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [7:0] char_code;
	logic char_valid;
	logic is_last;
	logic rsp_valid;
	logic rsp_stall;
	logic [63:0] fixed_value;

	decimal_parse_tracker tracker = new();
	logic [7:0] text_buf[$];
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	bit no_idle = 1'b0;
	bit held_off = 1'b0;

	ascii_decimal_to_fixed_point #(
		.FRAC_DIGITS(adfp_pkg::FRAC_DIGITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.char_code(char_code),
		.char_valid(char_valid),
		.is_last(is_last),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.fixed_value(fixed_value)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Offers one transaction after a random gap and waits until it is taken.
	task automatic send_char(input logic [7:0] code, input logic cv, input logic last);
		while (!no_idle && $urandom_range(99) < 28) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		char_code <= code;
		char_valid <= cv;
		is_last <= last;
		do
			@(posedge clk);
		while (req_stall);
		tracker.take_char(code, cv, last);
		items_sent++;
	endtask

	// Sends the buffered characters as one string; an open end closes it with a no-character item.
	task automatic send_buf(input bit open_end);
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], 1'b1, !open_end && (i == text_buf.size() - 1));
		if (open_end)
			send_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
		text_buf.delete();
	endtask

	task automatic send_text(input string s, input bit open_end);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_buf(open_end);
	endtask

	// A well-formed number with random content; a few are long enough to wrap.
	task automatic send_random_number();
		int n_int;
		int n_frac;
		bit open_end;
		if ($urandom_range(1))
			text_buf.push_back(CODE_MINUS);
		n_int = ($urandom_range(15) == 0) ? $urandom_range(25, 17) : $urandom_range(6);
		for (int i = 0; i < n_int; i++)
			text_buf.push_back(CODE_ZERO + 8'($urandom_range(9)));
		if ($urandom_range(3) != 0) begin
			text_buf.push_back(CODE_POINT);
			n_frac = $urandom_range(11);
			for (int i = 0; i < n_frac; i++)
				text_buf.push_back(CODE_ZERO + 8'($urandom_range(9)));
		end
		open_end = ($urandom_range(9) == 0) || (text_buf.size() == 0);
		send_buf(open_end);
	endtask

	// Arbitrary codes, stray signs and extra points.
	task automatic send_noise();
		int len;
		int pick;
		len = $urandom_range(8, 1);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(3);
			case (pick)
				0: text_buf.push_back(CODE_MINUS);
				1: text_buf.push_back(CODE_POINT);
				2: text_buf.push_back(CODE_ZERO + 8'($urandom_range(9)));
				default: text_buf.push_back(8'($urandom_range(255)));
			endcase
		end
		send_buf($urandom_range(4) == 0);
	endtask

	// Receiver: random stalls, one long hold-off once traffic is flowing.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && tracker.values_seen >= 100) begin
				held_off = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= !no_idle && ($urandom_range(99) < 28);
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_value(fixed_value);
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		char_code <= 8'd0;
		char_valid <= 1'b0;
		is_last <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty strings with either last flag, a lone minus, an early end.
		send_char(8'hA5, 1'b0, 1'b0);
		send_char(8'h5A, 1'b0, 1'b1);
		send_text("-", 1'b0);
		send_text("7", 1'b1);
		// A fraction longer than its width, then sign, point and digit.
		send_text(".123456789", 1'b0);
		send_text("-1.5", 1'b0);
		// Minus after the start and a second point.
		send_text("1-..", 1'b0);
		// Extreme codes.
		text_buf.push_back(8'hFF);
		text_buf.push_back(8'h00);
		send_buf(1'b0);

		// Random part, with a stretch where neither side idles.
		while (items_sent < ITEM_TARGET) begin
			no_idle = (items_sent >= 700) && (items_sent < 1000);
			if ($urandom_range(99) < 80)
				send_random_number();
			else if ($urandom_range(9) == 0)
				send_char(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
			else
				send_noise();
		end
		no_idle = 1'b0;
		req_valid <= 1'b0;

		while (tracker.owed_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters; checked %0d converted values, %0d mismatches.",
			items_sent, tracker.values_seen, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.owed_values.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
